/* hw/rtl/hdlbc_pkg.sv */
package hdlbc_pkg;

	// Request codes carried in the input selector.
	localparam logic [1:0] REQ_QUEUE = 2'd0;
	localparam logic [1:0] REQ_LINE  = 2'd1;
	localparam logic [1:0] REQ_FLUSH = 2'd2;

	// Result kinds.
	localparam logic KIND_LINE  = 1'b0;
	localparam logic KIND_FLUSH = 1'b1;

	localparam logic [7:0] PREAMBLE = 8'hFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_TX_RD,
		ST_TX_OUT,
		ST_FL_RD,
		ST_FL_OUT
	} state_t;

	typedef enum logic [1:0] {
		SEL_PRE,
		SEL_RING,
		SEL_FLUSH
	} out_sel_t;

	typedef struct packed {
		logic     cap_in;
		logic     ring_wr;
		logic     tx_rd;
		logic     tail_inc;
		logic     set_tx;
		logic     clr_tx;
		logic     set_await;
		logic     clr_await;
		logic     rx_wr;
		logic     rx_rd;
		logic     idx_inc;
		logic     flush_clr;
		logic     load_out;
		out_sel_t out_sel;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       byte_zero;
		logic       ring_full;
		logic       ring_empty;
		logic       transmitting;
		logic       awaiting;
		logic       tx_empty;
		logic       rx_ok;
		logic       rx_nonempty;
		logic       flush_last;
		logic       out_free;
	} dp_stat_t;

endpackage

/* hw/rtl/half_duplex_link_buffer_controller_core.sv */
// Buffer controller for a single-wire half-duplex serial link.
// The input stream (s_*) carries one event per item: the request code in s_tuser
// (queue a host byte, line interrupt, or tick flush) and the byte and line flags
// in s_tdata. The output stream (m_*) carries bytes driven onto the line
// (m_tuser 0) and bytes of a flushed receive packet (m_tuser 1, m_tlast on the
// final one); m_tdata also reports the link mode after the event.
// Items are handled one at a time. An event is accepted in the idle state and
// handled in an execute state; sending a queued byte goes on through a ring read
// state and an output state, because the transmit ring is a memory with a
// registered read port. A flush streams RX_LEN bytes, each through a read state
// and an output state, because the packet buffer also has a registered read.
// A result sits in an output register; the block accepts the next item while it
// waits, but stops before producing another result until the receiver takes it,
// so a stalled receiver holds the block and nothing is lost.
// Reset puts the link in receive mode with an empty ring and an empty packet.
// The packet buffer needs no clearing pass: its fill count marks which entries
// hold data, and entries beyond it are given out as zero.
module half_duplex_link_buffer_controller_core #(
	parameter int TX_DEPTH = 64,
	parameter int RX_LEN   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// data_byte[7:0], tx_empty[8], rx_ready[9], framing_error[10],
	// overrun_error[11], zero padding[15:12]
	input  logic [15:0] s_tdata,
	// req_type[1:0]
	input  logic [1:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_byte[7:0], in_transmit[8], zero padding[15:9]
	output logic [15:0] m_tdata,
	// out_last
	output logic        m_tlast,
	// out_kind[0]
	output logic        m_tuser
);

	// Commands from the controller and status back from the datapath.
	hdlbc_pkg::dp_cmd_t  cmd;
	hdlbc_pkg::dp_stat_t st;

	hdlbc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	hdlbc_dp #(
		.TX_DEPTH (TX_DEPTH),
		.RX_LEN   (RX_LEN)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cmd      (cmd),
		.st       (st)
	);

endmodule

/* hw/rtl/hdlbc_ctrl.sv */
module hdlbc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  hdlbc_pkg::dp_stat_t st,
	output hdlbc_pkg::dp_cmd_t  cmd
);

	hdlbc_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hdlbc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.out_sel = hdlbc_pkg::SEL_PRE;
		s_tready    = 1'b0;
		unique case (state_q)
			hdlbc_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.cap_in = 1'b1;
					state_d    = hdlbc_pkg::ST_EXEC;
				end
			end
			hdlbc_pkg::ST_EXEC: begin
				unique case (st.req)
					hdlbc_pkg::REQ_QUEUE: begin
						if (st.byte_zero || st.ring_full) begin
							state_d = hdlbc_pkg::ST_IDLE;
						end else if (st.transmitting) begin
							cmd.ring_wr = 1'b1;
							state_d     = hdlbc_pkg::ST_IDLE;
						end else if (st.out_free) begin
							// First byte in receive mode: turn the link round.
							cmd.ring_wr   = 1'b1;
							cmd.set_tx    = 1'b1;
							cmd.clr_await = 1'b1;
							cmd.load_out  = 1'b1;
							cmd.out_sel   = hdlbc_pkg::SEL_PRE;
							state_d       = hdlbc_pkg::ST_IDLE;
						end
					end
					hdlbc_pkg::REQ_LINE: begin
						if (!st.transmitting) begin
							cmd.rx_wr = st.rx_ok;
							state_d   = hdlbc_pkg::ST_IDLE;
						end else if (st.awaiting && st.ring_empty) begin
							// Transmit complete with nothing queued: back to receive.
							if (st.out_free) begin
								cmd.clr_tx    = 1'b1;
								cmd.clr_await = 1'b1;
								cmd.load_out  = 1'b1;
								cmd.out_sel   = hdlbc_pkg::SEL_PRE;
								state_d       = hdlbc_pkg::ST_IDLE;
							end
						end else if (st.ring_empty) begin
							cmd.set_await = 1'b1;
							state_d       = hdlbc_pkg::ST_IDLE;
						end else begin
							cmd.clr_await = 1'b1;
							state_d = st.tx_empty ? hdlbc_pkg::ST_TX_RD : hdlbc_pkg::ST_IDLE;
						end
					end
					hdlbc_pkg::REQ_FLUSH: begin
						state_d = st.rx_nonempty ? hdlbc_pkg::ST_FL_RD : hdlbc_pkg::ST_IDLE;
					end
					default: begin
						state_d = hdlbc_pkg::ST_IDLE;
					end
				endcase
			end
			hdlbc_pkg::ST_TX_RD: begin
				cmd.tx_rd = 1'b1;
				state_d   = hdlbc_pkg::ST_TX_OUT;
			end
			hdlbc_pkg::ST_TX_OUT: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = hdlbc_pkg::SEL_RING;
					cmd.tail_inc = 1'b1;
					state_d      = hdlbc_pkg::ST_IDLE;
				end
			end
			hdlbc_pkg::ST_FL_RD: begin
				cmd.rx_rd = 1'b1;
				state_d   = hdlbc_pkg::ST_FL_OUT;
			end
			hdlbc_pkg::ST_FL_OUT: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					cmd.out_sel  = hdlbc_pkg::SEL_FLUSH;
					cmd.idx_inc  = 1'b1;
					if (st.flush_last) begin
						cmd.flush_clr = 1'b1;
						state_d       = hdlbc_pkg::ST_IDLE;
					end else begin
						state_d = hdlbc_pkg::ST_FL_RD;
					end
				end
			end
			default: begin
				state_d = hdlbc_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

/* hw/rtl/hdlbc_dp.sv */
module hdlbc_dp #(
	parameter int TX_DEPTH = 64,
	parameter int RX_LEN   = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         s_tdata,
	input  logic [1:0]          s_tuser,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [15:0]         m_tdata,
	output logic                m_tlast,
	output logic                m_tuser,
	input  hdlbc_pkg::dp_cmd_t  cmd,
	output hdlbc_pkg::dp_stat_t st
);

	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int RX_AW = (RX_LEN > 1) ? $clog2(RX_LEN) : 1;
	localparam int RX_CW = $clog2(RX_LEN + 1);
	localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
	localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_LEN - 1);

	// Captured item.
	logic [1:0] req_q;
	logic [7:0] byte_q;
	logic       txe_q, rxr_q, ferr_q, oerr_q;

	// Transmit ring and link mode.
	logic [7:0]       ring_mem [TX_DEPTH];
	logic [7:0]       ring_rd_q;
	logic [TX_AW-1:0] head_q, tail_q, head_nx, tail_nx;
	logic             tx_q, await_q;

	// Receive packet; entries at or beyond the fill count read as zero.
	logic [7:0]       rx_mem [RX_LEN];
	logic [7:0]       rx_rd_q;
	logic [RX_CW-1:0] rx_cnt_q;
	logic [RX_AW-1:0] idx_q;

	// Output register.
	logic       ov_q, okind_q, olast_q, otx_q;
	logic [7:0] obyte_q;
	logic [7:0] obyte_d;
	logic       otx_d;

	assign head_nx = (head_q == TX_LAST) ? '0 : head_q + 1'b1;
	assign tail_nx = (tail_q == TX_LAST) ? '0 : tail_q + 1'b1;

	always_ff @(posedge clk) begin
		if (cmd.cap_in) begin
			req_q  <= s_tuser;
			byte_q <= s_tdata[7:0];
			txe_q  <= s_tdata[8];
			rxr_q  <= s_tdata[9];
			ferr_q <= s_tdata[10];
			oerr_q <= s_tdata[11];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ring_wr) begin
			ring_mem[head_q] <= byte_q;
		end
		if (cmd.tx_rd) begin
			ring_rd_q <= ring_mem[tail_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rx_wr) begin
			rx_mem[rx_cnt_q[RX_AW-1:0]] <= byte_q;
		end
		if (cmd.rx_rd) begin
			rx_rd_q <= rx_mem[idx_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			tx_q     <= 1'b0;
			await_q  <= 1'b0;
			rx_cnt_q <= '0;
			idx_q    <= '0;
		end else begin
			if (cmd.ring_wr) head_q <= head_nx;
			if (cmd.tail_inc) tail_q <= tail_nx;
			if (cmd.set_tx) begin
				tx_q <= 1'b1;
			end else if (cmd.clr_tx) begin
				tx_q <= 1'b0;
			end
			if (cmd.set_await) begin
				await_q <= 1'b1;
			end else if (cmd.clr_await) begin
				await_q <= 1'b0;
			end
			if (cmd.flush_clr) begin
				rx_cnt_q <= '0;
				idx_q    <= '0;
			end else begin
				if (cmd.rx_wr) rx_cnt_q <= rx_cnt_q + 1'b1;
				if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		unique case (cmd.out_sel)
			hdlbc_pkg::SEL_PRE:   obyte_d = hdlbc_pkg::PREAMBLE;
			hdlbc_pkg::SEL_RING:  obyte_d = ring_rd_q;
			hdlbc_pkg::SEL_FLUSH: obyte_d = (RX_CW'(idx_q) < rx_cnt_q) ? rx_rd_q : 8'h00;
			default:              obyte_d = hdlbc_pkg::PREAMBLE;
		endcase
		otx_d = cmd.set_tx ? 1'b1 : (cmd.clr_tx ? 1'b0 : tx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.load_out) begin
			ov_q <= 1'b1;
		end else if (m_tready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			obyte_q <= obyte_d;
			otx_q   <= otx_d;
			okind_q <= (cmd.out_sel == hdlbc_pkg::SEL_FLUSH) ? hdlbc_pkg::KIND_FLUSH
			                                                 : hdlbc_pkg::KIND_LINE;
			olast_q <= (cmd.out_sel == hdlbc_pkg::SEL_FLUSH) && (idx_q == RX_LAST);
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata  = {7'd0, otx_q, obyte_q};
	assign m_tlast  = olast_q;
	assign m_tuser  = okind_q;

	always_comb begin
		st.req          = req_q;
		st.byte_zero    = (byte_q == 8'h00);
		st.ring_full    = (head_nx == tail_q);
		st.ring_empty   = (head_q == tail_q);
		st.transmitting = tx_q;
		st.awaiting     = await_q;
		st.tx_empty     = txe_q;
		st.rx_ok        = rxr_q && !ferr_q && !oerr_q && (rx_cnt_q < RX_CW'(RX_LEN));
		st.rx_nonempty  = (rx_cnt_q != '0);
		st.flush_last   = (idx_q == RX_LAST);
		st.out_free     = !ov_q || m_tready;
	end

endmodule
